### hdl/dpbp_pkg.sv
// Shared constants, types and helper functions for the depth pixel back-projection block.
package dpbp_pkg;

   localparam int IMAGE_WIDTH    = 640;
   localparam int IMAGE_HEIGHT   = 480;
   localparam int COL_BITS       = 10;
   localparam int ROW_BITS       = 9;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [13:0] PRINCIPAL_X_RESET = 14'd5112;
   localparam logic [13:0] PRINCIPAL_Y_RESET = 14'd3832;
   localparam logic [23:0] INV_FOCAL_X_RESET = 24'd31957;
   localparam logic [23:0] INV_FOCAL_Y_RESET = 24'd31957;
   localparam logic [15:0] NEAR_LIMIT_RESET  = 16'd300;
   localparam logic [15:0] FAR_LIMIT_RESET   = 16'd7000;
   localparam logic [3:0]  FRAME_SKIP_RESET  = 4'd5;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PRINCIPAL_X = 3'd0,
      CSR_PRINCIPAL_Y = 3'd1,
      CSR_INV_FOCAL_X = 3'd2,
      CSR_INV_FOCAL_Y = 3'd3,
      CSR_NEAR_LIMIT  = 3'd4,
      CSR_FAR_LIMIT   = 3'd5,
      CSR_FRAME_SKIP  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] row;
      logic                keep;
      logic                last;
   } raster_info_type;

   // entry {frame_skip, skip_count} holds (skip_count + 1) mod (frame_skip + 1)
   typedef logic [255:0][3:0] skip_table_type;

   function automatic skip_table_type build_skip_table();
      skip_table_type t;
      int r;
      t = '0;
      for (int b = 0; b < 16; b++) begin
         for (int a = 0; a < 16; a++) begin
            r = a + 1;
            for (int k = 0; k < 16; k++) begin
               if (r >= b + 1) begin
                  r = r - (b + 1);
               end
            end
            t[b * 16 + a] = 4'(r);
         end
      end
      return t;
   endfunction

   localparam skip_table_type SKIP_TABLE = build_skip_table();

   function automatic logic signed [31:0] sat_ray(input logic signed [36:0] v);
      logic signed [31:0] r;
      if ((&v[36:31]) || !(|v[36:31])) begin
         r = v[31:0];
      end else if (v[36]) begin
         r = {1'b1, {31{1'b0}}};
      end else begin
         r = {1'b0, {31{1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [17:0] sat_coord(input logic signed [24:0] v);
      logic signed [17:0] r;
      if ((&v[24:17]) || !(|v[24:17])) begin
         r = v[17:0];
      end else if (v[24]) begin
         r = {1'b1, {17{1'b0}}};
      end else begin
         r = {1'b0, {17{1'b1}}};
      end
      return r;
   endfunction

endpackage

### hdl/dpbp_raster.sv
// Raster position, frame-skip tracking and depth window test for each accepted word.
module dpbp_raster import dpbp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic            frame_start,
   input  logic [15:0]     depth_mm,
   input  logic [3:0]      frame_skip,
   input  logic [15:0]     near_limit_mm,
   input  logic [15:0]     far_limit_mm,
   output raster_info_type info
);

   logic [COL_BITS-1:0] col_ff, col_in, col_cur;
   logic [ROW_BITS-1:0] row_ff, row_in, row_cur;
   logic [3:0]          skip_ff, skip_cur;
   logic                col_end, row_end;

   assign col_cur  = frame_start ? '0 : col_ff;
   assign row_cur  = frame_start ? '0 : row_ff;
   assign skip_cur = frame_start ? SKIP_TABLE[{frame_skip, skip_ff}] : skip_ff;

   assign col_end = (col_cur == COL_BITS'(IMAGE_WIDTH - 1));
   assign row_end = (row_cur == ROW_BITS'(IMAGE_HEIGHT - 1));

   always_comb begin
      if (col_end) begin
         col_in = '0;
         row_in = row_end ? '0 : row_cur + 1'b1;
      end else begin
         col_in = col_cur + 1'b1;
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         skip_ff <= FRAME_SKIP_RESET;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         skip_ff <= skip_cur;
      end
   end

   assign info.col  = col_cur;
   assign info.row  = row_cur;
   assign info.keep = (skip_cur == 4'd0) && (depth_mm > near_limit_mm) &&
                      (depth_mm < far_limit_mm);
   assign info.last = col_end && row_end;

endmodule

### hdl/dpbp_axis.sv
// Three-stage ray factor and coordinate pipeline for one image axis.
module dpbp_axis import dpbp_pkg::*; (
   input  logic                clock,
   input  logic                advance,
   input  logic [13:0]         center_q4,
   input  logic [COL_BITS-1:0] pos,
   input  logic [23:0]         inv_focal,
   input  logic [15:0]         depth_mm,
   output logic signed [17:0]  coord_mm
);

   logic signed [15:0] diff;
   logic signed [40:0] prod1_in, prod1_ff;
   logic        [15:0] depth1_ff;
   logic signed [31:0] ray;
   logic signed [48:0] prod2_in, prod2_ff;
   logic signed [17:0] coord_ff;

   assign diff     = $signed({2'b00, center_q4}) - $signed({2'b00, pos, 4'b0000});
   assign prod1_in = diff * $signed({1'b0, inv_focal});
   assign ray      = sat_ray(prod1_ff[40:4]);
   assign prod2_in = ray * $signed({1'b0, depth1_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         prod1_ff  <= prod1_in;
         depth1_ff <= depth_mm;
         prod2_ff  <= prod2_in;
         coord_ff  <= sat_coord(prod2_ff[48:24]);
      end
   end

   assign coord_mm = coord_ff;

endmodule

### hdl/depth_pixel_back_projection.sv
// Top level: settings registers, word pipeline with stall control, and both axis pipelines.
// An accepted input word passes the stage 1, 2 and 3 registers to become its result word.
// Throughput: one word per cycle unless stalled, from the three-stage multiplier pipeline.
// A result waiting under stall holds the whole pipeline; input is stalled only then.
// Reset clears valid bits, raster counters and settings to their defaults;
// the skip counter restarts so that, with the default frame skip, the first frame is used.
module depth_pixel_back_projection import dpbp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [15:0]               req_depth_mm,
   input  logic                      req_frame_start,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_point_keep,
   output logic signed [17:0]        rsp_point_x_mm,
   output logic signed [17:0]        rsp_point_y_mm,
   output logic [15:0]               rsp_point_z_mm,
   output logic                      rsp_frame_end,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [13:0] principal_x_ff, principal_y_ff;
   logic [23:0] inv_focal_x_ff, inv_focal_y_ff;
   logic [15:0] near_limit_ff, far_limit_ff;
   logic [3:0]  frame_skip_ff;

   logic            advance, accept;
   logic            v1_ff, v2_ff, v3_ff;
   logic [15:0]     z1_ff, z2_ff, z3_ff;
   logic            keep1_ff, keep2_ff, keep3_ff;
   logic            last1_ff, last2_ff, last3_ff;
   raster_info_type info;

   always_ff @(posedge clock) begin
      if (reset) begin
         principal_x_ff <= PRINCIPAL_X_RESET;
         principal_y_ff <= PRINCIPAL_Y_RESET;
         inv_focal_x_ff <= INV_FOCAL_X_RESET;
         inv_focal_y_ff <= INV_FOCAL_Y_RESET;
         near_limit_ff  <= NEAR_LIMIT_RESET;
         far_limit_ff   <= FAR_LIMIT_RESET;
         frame_skip_ff  <= FRAME_SKIP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_PRINCIPAL_X: principal_x_ff <= csr_wdata[13:0];
            CSR_PRINCIPAL_Y: principal_y_ff <= csr_wdata[13:0];
            CSR_INV_FOCAL_X: inv_focal_x_ff <= csr_wdata[23:0];
            CSR_INV_FOCAL_Y: inv_focal_y_ff <= csr_wdata[23:0];
            CSR_NEAR_LIMIT:  near_limit_ff  <= csr_wdata[15:0];
            CSR_FAR_LIMIT:   far_limit_ff   <= csr_wdata[15:0];
            CSR_FRAME_SKIP:  frame_skip_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // advance the whole pipeline unless a result word is held
   assign advance   = !v3_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   dpbp_raster u_raster (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .frame_start   (req_frame_start),
      .depth_mm      (req_depth_mm),
      .frame_skip    (frame_skip_ff),
      .near_limit_mm (near_limit_ff),
      .far_limit_mm  (far_limit_ff),
      .info          (info)
   );

   dpbp_axis u_axis_x (
      .clock     (clock),
      .advance   (advance),
      .center_q4 (principal_x_ff),
      .pos       (info.col),
      .inv_focal (inv_focal_x_ff),
      .depth_mm  (req_depth_mm),
      .coord_mm  (rsp_point_x_mm)
   );

   dpbp_axis u_axis_y (
      .clock     (clock),
      .advance   (advance),
      .center_q4 (principal_y_ff),
      .pos       (COL_BITS'(info.row)),
      .inv_focal (inv_focal_y_ff),
      .depth_mm  (req_depth_mm),
      .coord_mm  (rsp_point_y_mm)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         z1_ff    <= req_depth_mm;
         keep1_ff <= info.keep;
         last1_ff <= info.last;
         z2_ff    <= z1_ff;
         keep2_ff <= keep1_ff;
         last2_ff <= last1_ff;
         z3_ff    <= z2_ff;
         keep3_ff <= keep2_ff;
         last3_ff <= last2_ff;
      end
   end

   assign rsp_valid      = v3_ff;
   assign rsp_point_keep = keep3_ff;
   assign rsp_point_z_mm = z3_ff;
   assign rsp_frame_end  = last3_ff;

   a_keep_nonzero_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_point_keep |-> rsp_point_z_mm != 16'd0)
      else $error("kept point with zero depth");

   a_zero_depth_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_point_z_mm == 16'd0) |->
         (rsp_point_x_mm == 18'sd0) && (rsp_point_y_mm == 18'sd0))
      else $error("zero depth gave nonzero coordinates");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      v1_ff && advance |=> v2_ff)
      else $error("pipeline word lost between stages");

endmodule

### tb/tb_top.sv
// Self-checking bench for depth_pixel_back_projection: directed table and random frames.
module tb_top;
   import dpbp_pkg::*;

   localparam int LATENCY = 3;
   localparam int PLAN_LEN = 43;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic               keep;
      logic signed [17:0] x;
      logic signed [17:0] y;
      logic [15:0]        z;
      logic               last;
   } point_word_type;

   typedef struct packed {
      logic                      is_write;
      logic [CSR_INDEX_BITS-1:0] reg_idx;
      logic [CSR_DATA_BITS-1:0]  reg_val;
      logic [15:0]               depth;
      logic                      start;
      logic                      typed;
      point_word_type            want;
   } plan_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [15:0]               req_depth_mm = '0;
   logic                      req_frame_start = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_point_keep;
   logic signed [17:0]        rsp_point_x_mm;
   logic signed [17:0]        rsp_point_y_mm;
   logic [15:0]               rsp_point_z_mm;
   logic                      rsp_frame_end;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   logic [13:0] cfg_cx, cfg_cy;
   logic [23:0] cfg_fx, cfg_fy;
   logic [15:0] cfg_near, cfg_far;
   logic [3:0]  cfg_skip;
   int          col_pos, row_pos, skip_pos;

   point_word_type pending_points[$];
   int             mismatches = 0;
   int             burst_left = 0;
   int             gap_max = 4;
   int             stall_left = 0;
   int             stall_mode = 0;

   depth_pixel_back_projection uut (.*);

   always #4 clock = ~clock;

   function automatic int ray_scale(input logic [13:0] center, input int pos,
                                    input logic [23:0] inv);
      longint r;
      r = ((longint'(center) - 16 * longint'(pos)) * longint'(inv)) >>> 4;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return int'(r);
   endfunction

   function automatic logic signed [17:0] scale_depth(input int ray, input logic [15:0] depth);
      longint v;
      v = (longint'(ray) * longint'(depth)) >>> 24;
      if (v > 131071) v = 131071;
      if (v < -131072) v = -131072;
      return v[17:0];
   endfunction

   function automatic point_word_type back_project(input logic [15:0] depth, input logic start);
      point_word_type p;
      if (start) begin
         col_pos = 0;
         row_pos = 0;
         skip_pos = (skip_pos + 1) % (int'(cfg_skip) + 1);
      end
      p.keep = (skip_pos == 0) && (depth > cfg_near) && (depth < cfg_far);
      p.x = scale_depth(ray_scale(cfg_cx, col_pos, cfg_fx), depth);
      p.y = scale_depth(ray_scale(cfg_cy, row_pos, cfg_fy), depth);
      p.z = depth;
      p.last = (col_pos == IMAGE_WIDTH - 1) && (row_pos == IMAGE_HEIGHT - 1);
      if (col_pos + 1 >= IMAGE_WIDTH) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= IMAGE_HEIGHT) ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
      return p;
   endfunction

   function automatic plan_row_type setting_row(input logic [CSR_INDEX_BITS-1:0] idx,
                                                input logic [CSR_DATA_BITS-1:0] val);
      plan_row_type r;
      r = '0;
      r.is_write = 1'b1;
      r.reg_idx = idx;
      r.reg_val = val;
      return r;
   endfunction

   function automatic plan_row_type pixel_row(input logic [15:0] depth, input logic start);
      plan_row_type r;
      r = '0;
      r.depth = depth;
      r.start = start;
      return r;
   endfunction

   function automatic plan_row_type pinned_row(input logic [15:0] depth, input logic start,
                                               input logic keep, input int x, input int y,
                                               input logic last);
      plan_row_type r;
      r = pixel_row(depth, start);
      r.typed = 1'b1;
      r.want.keep = keep;
      r.want.x = x[17:0];
      r.want.y = y[17:0];
      r.want.z = depth;
      r.want.last = last;
      return r;
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_setting(input int lo, input int hi,
                                                            input int typ_lo, input int typ_hi);
      case ($urandom_range(0, 4))
         0: return CSR_DATA_BITS'(lo);
         1: return CSR_DATA_BITS'(hi);
         2: return CSR_DATA_BITS'($urandom_range(lo, hi));
         default: return CSR_DATA_BITS'($urandom_range(typ_lo, typ_hi));
      endcase
   endfunction

   function automatic logic [15:0] pick_depth();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return cfg_near + 16'($urandom_range(0, 2)) - 16'd1;
         3: return cfg_far + 16'($urandom_range(0, 2)) - 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_PRINCIPAL_X: cfg_cx = val[13:0];
         CSR_PRINCIPAL_Y: cfg_cy = val[13:0];
         CSR_INV_FOCAL_X: cfg_fx = val[23:0];
         CSR_INV_FOCAL_Y: cfg_fy = val[23:0];
         CSR_NEAR_LIMIT:  cfg_near = val[15:0];
         CSR_FAR_LIMIT:   cfg_far = val[15:0];
         CSR_FRAME_SKIP:  cfg_skip = val[3:0];
         default: ;
      endcase
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (LATENCY + 1) @(posedge clock);
   endtask

   task automatic send_pixel(input logic [15:0] depth, input logic start, input logic typed,
                             input point_word_type want);
      point_word_type predicted;
      int gap;
      csr_wr_en <= 1'b0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_depth_mm <= depth;
      req_frame_start <= start;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predicted = back_project(depth, start);
      pending_points.insert(pending_points.size(), typed ? want : predicted);
   endtask

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(50, 400);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (stall_left % 4 == 0);
      endcase
   end

   always @(posedge clock) begin
      point_word_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_point_keep, rsp_point_x_mm, rsp_point_y_mm, rsp_point_z_mm, rsp_frame_end};
         if (pending_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: keep=%0d x=%0d y=%0d z=%0d end=%0d", got.keep,
                        $signed(got.x), $signed(got.y), got.z, got.last);
         end else begin
            want = pending_points.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected keep=%0d x=%0d y=%0d z=%0d end=%0d, %s",
                           want.keep, $signed(want.x), $signed(want.y), want.z, want.last,
                           $sformatf("got keep=%0d x=%0d y=%0d z=%0d end=%0d", got.keep,
                                     $signed(got.x), $signed(got.y), got.z, got.last));
            end
         end
      end
   end

   initial begin
      #(8 * 4_000_000);
      $display("FAILURE");
      $finish;
   end

   initial begin
      plan_row_type plan [PLAN_LEN];
      logic         start;
      int           frame_left;
      logic         was_write;
      plan = '{
         pinned_row(16'd0, 1'b0, 1'b0, 0, 0, 1'b0),
         pixel_row(16'd1000, 1'b0),
         pixel_row(16'd1000, 1'b1),
         pixel_row(16'd300, 1'b0),
         pixel_row(16'd301, 1'b0),
         pixel_row(16'd6999, 1'b0),
         pixel_row(16'd7000, 1'b0),
         pixel_row(16'hFFFF, 1'b0),
         pinned_row(16'd0, 1'b0, 1'b0, 0, 0, 1'b0),
         setting_row(CSR_FRAME_SKIP, 24'd0),
         setting_row(CSR_UNUSED, 24'hFFFFFF),
         pixel_row(16'd5000, 1'b1),
         setting_row(CSR_PRINCIPAL_X, 24'd16383),
         setting_row(CSR_PRINCIPAL_Y, 24'd16383),
         setting_row(CSR_INV_FOCAL_X, 24'hFFFFFF),
         setting_row(CSR_INV_FOCAL_Y, 24'hFFFFFF),
         setting_row(CSR_NEAR_LIMIT, 24'd0),
         setting_row(CSR_FAR_LIMIT, 24'd65535),
         pinned_row(16'hFFFF, 1'b1, 1'b0, 131071, 131071, 1'b0),
         pinned_row(16'd1, 1'b0, 1'b1, 127, 127, 1'b0),
         pinned_row(16'd0, 1'b0, 1'b0, 0, 0, 1'b0),
         setting_row(CSR_PRINCIPAL_X, 24'd0),
         setting_row(CSR_PRINCIPAL_Y, 24'd0),
         pinned_row(16'hFFFF, 1'b1, 1'b0, 0, 0, 1'b0),
         pixel_row(16'd1, 1'b0),
         pixel_row(16'd40000, 1'b0),
         pinned_row(16'hFFFF, 1'b0, 1'b0, -131072, 0, 1'b0),
         setting_row(CSR_FRAME_SKIP, 24'd15),
         setting_row(CSR_NEAR_LIMIT, 24'd65535),
         setting_row(CSR_FAR_LIMIT, 24'd0),
         pixel_row(16'd1234, 1'b1),
         pixel_row(16'd1234, 1'b1),
         pixel_row(16'd9, 1'b0),
         setting_row(CSR_PRINCIPAL_X, 24'(PRINCIPAL_X_RESET)),
         setting_row(CSR_PRINCIPAL_Y, 24'(PRINCIPAL_Y_RESET)),
         setting_row(CSR_INV_FOCAL_X, INV_FOCAL_X_RESET),
         setting_row(CSR_INV_FOCAL_Y, INV_FOCAL_Y_RESET),
         setting_row(CSR_NEAR_LIMIT, 24'(NEAR_LIMIT_RESET)),
         setting_row(CSR_FAR_LIMIT, 24'(FAR_LIMIT_RESET)),
         setting_row(CSR_FRAME_SKIP, 24'd0),
         pixel_row(16'd2000, 1'b1),
         pixel_row(16'h5555, 1'b0),
         pixel_row(16'hAAAA, 1'b0)
      };
      cfg_cx = PRINCIPAL_X_RESET;
      cfg_cy = PRINCIPAL_Y_RESET;
      cfg_fx = INV_FOCAL_X_RESET;
      cfg_fy = INV_FOCAL_Y_RESET;
      cfg_near = NEAR_LIMIT_RESET;
      cfg_far = FAR_LIMIT_RESET;
      cfg_skip = FRAME_SKIP_RESET;
      col_pos = 0;
      row_pos = 0;
      skip_pos = int'(FRAME_SKIP_RESET);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      was_write = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            if (!was_write) drain_pipeline();
            write_reg(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            send_pixel(plan[i].depth, plan[i].start, plan[i].typed, plan[i].want);
         end
         was_write = plan[i].is_write;
      end

      for (int phase = 0; phase < 8; phase++) begin
         drain_pipeline();
         write_reg(CSR_PRINCIPAL_X, pick_setting(0, 16383, 0, 16383));
         write_reg(CSR_PRINCIPAL_Y, pick_setting(0, 16383, 0, 16383));
         write_reg(CSR_INV_FOCAL_X, pick_setting(1, 16777215, 15000, 60000));
         write_reg(CSR_INV_FOCAL_Y, pick_setting(1, 16777215, 15000, 60000));
         write_reg(CSR_NEAR_LIMIT, pick_setting(0, 65535, 0, 2000));
         write_reg(CSR_FAR_LIMIT, pick_setting(0, 65535, 2000, 65535));
         write_reg(CSR_FRAME_SKIP, pick_setting(0, 15, 0, 3));
         if ($urandom_range(0, 1) == 1) write_reg(CSR_UNUSED, 24'($urandom));
         gap_max = (phase % 3 == 0) ? 0 : $urandom_range(1, 12);
         frame_left = 0;
         repeat (250) begin
            start = 1'b0;
            if (frame_left == 0) begin
               start = 1'b1;
               frame_left = ($urandom_range(0, 3) == 0) ? $urandom_range(600, 2000)
                                                        : $urandom_range(1, 60);
            end
            frame_left--;
            send_pixel(pick_depth(), start, 1'b0, '0);
         end
      end

      drain_pipeline();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### depth_pixel_back_projection.f
hdl/dpbp_pkg.sv
hdl/dpbp_raster.sv
hdl/dpbp_axis.sv
hdl/depth_pixel_back_projection.sv
tb/tb_top.sv
